// ===== src/ame_pkg.sv =====
// Package for the accumulator machine execute unit: payload structs, codes, sizes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package ame_pkg;

    localparam int MemDepth = 256;
    localparam int AddrW    = $clog2(MemDepth);
    localparam int CountW   = AddrW + 1;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_EXEC   = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [4:0] OP_CLEAR  = 5'd0;
    localparam logic [4:0] OP_AT     = 5'd1;
    localparam logic [4:0] OP_SET    = 5'd2;
    localparam logic [4:0] OP_INSERT = 5'd3;
    localparam logic [4:0] OP_ERASE  = 5'd4;
    localparam logic [4:0] OP_ADDC   = 5'd5;
    localparam logic [4:0] OP_SUBC   = 5'd6;
    localparam logic [4:0] OP_MULC   = 5'd7;
    localparam logic [4:0] OP_DIVC   = 5'd8;
    localparam logic [4:0] OP_ADDM   = 5'd9;
    localparam logic [4:0] OP_SUBM   = 5'd10;
    localparam logic [4:0] OP_MULM   = 5'd11;
    localparam logic [4:0] OP_DIVM   = 5'd12;
    localparam logic [4:0] OP_JREL   = 5'd13;
    localparam logic [4:0] OP_JZ     = 5'd14;
    localparam logic [4:0] OP_JNZ    = 5'd15;
    localparam logic [4:0] OP_NOOP   = 5'd16;
    localparam logic [4:0] OP_HALT   = 5'd17;
    localparam logic [4:0] OP_OUTPUT = 5'd18;
    localparam logic [4:0] OP_CHECK  = 5'd19;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         opcode;
        logic signed [31:0] argument;
        logic signed [63:0] data_word;
        logic [7:0]         read_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pc_step;
        logic signed [63:0] acc_value;
        logic signed [63:0] read_word;
        logic [8:0]         mem_size;
    } t_rsp;

    // Command to the shared arithmetic unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_cmd;

endpackage

// ===== src/ame_muldiv.sv =====
// Iterative 64-bit multiplier and signed divider for the execute unit.
// Depends on ame_pkg.
`timescale 1ns / 1ps
module ame_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ame_pkg::t_alu_cmd  i_cmd,
    output logic               o_done,
    output logic [63:0]        o_result
);
    // Multiply: 16 steps of 64x4 partial products. Divide: 64 restoring steps.
    logic        r_busy, n_busy;
    logic        r_div;
    logic [6:0]  r_cnt;
    logic [63:0] r_a, r_b, r_q, r_acc;
    logic [64:0] r_rem;
    logic        r_neg;
    logic [64:0] w_trial;
    logic [63:0] w_part;
    logic [63:0] w_abs_a, w_abs_b;

    assign w_abs_a = i_cmd.a[63] ? 64'(-i_cmd.a) : i_cmd.a;
    assign w_abs_b = i_cmd.b[63] ? 64'(-i_cmd.b) : i_cmd.b;
    assign w_trial = {r_rem[63:0], r_q[63]} - {1'b0, r_b};
    assign w_part  = r_b * {60'd0, r_a[3:0]};

    always_comb begin
        n_busy = r_busy;
        if (i_cmd.start) n_busy = 1'b1;
        else if (r_busy && ((r_div && r_cnt == 7'd63) || (!r_div && r_cnt == 7'd15)))
            n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            o_done <= r_busy && !n_busy;
        end
        if (i_cmd.start) begin
            r_div <= i_cmd.is_div;
            r_cnt <= '0;
            r_acc <= '0;
            r_rem <= '0;
            if (i_cmd.is_div) begin
                r_q   <= w_abs_a;
                r_b   <= w_abs_b;
                r_neg <= i_cmd.a[63] ^ i_cmd.b[63];
            end else begin
                r_a   <= i_cmd.a;
                r_b   <= i_cmd.b;
                r_neg <= 1'b0;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_div) begin
                if (!w_trial[64]) begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[63:0], r_q[63]};
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end else begin
                r_acc <= r_acc + w_part;
                r_a   <= {4'd0, r_a[63:4]};
                r_b   <= {r_b[59:0], 4'd0};
            end
        end
    end

    assign o_result = r_div ? (r_neg ? 64'(-r_q) : r_q) : r_acc;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_cmd.start) else $error("arithmetic unit restarted while busy");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while still busy");
    a_cnt_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 7'd63) else $error("step count out of range");
`endif
endmodule

// ===== src/accumulator_machine_execute.sv =====
// Top level of the accumulator machine execute unit: sequencer and data memory.
// Depends on ame_pkg and ame_muldiv.
// Sequence: append, read and most executes pass S_RD, S_EXEC and S_RESP before o_done;
// multiply and divide wait in S_ALU for the arithmetic unit, and insert or erase
// alternate S_SHRD and S_SHWR once per shifted word, as the memory read is registered.
// One request at a time; busy stays low from the result strobe on, so the
// next request can be accepted in the o_done cycle.
// Reset clears the accumulator, the word count and the status; memory contents
// stay undefined and are never read before written. The receiver cannot stall.
`timescale 1ns / 1ps
module accumulator_machine_execute (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ame_pkg::t_req   i_req,
    output logic            o_done,
    output ame_pkg::t_rsp   o_rsp
);
    localparam int AW = ame_pkg::AddrW;
    localparam int CW = ame_pkg::CountW;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1; // wait for memory read data
    localparam logic [2:0] S_EXEC  = 3'd2; // decide with read data
    localparam logic [2:0] S_ALU   = 3'd3; // wait for multiply or divide
    localparam logic [2:0] S_SHRD  = 3'd4; // shift: read phase
    localparam logic [2:0] S_SHWR  = 3'd5; // shift: write phase
    localparam logic [2:0] S_RESP  = 3'd6;

    logic [2:0]          r_state, n_state;
    ame_pkg::t_req       r_req;
    logic [63:0]         r_acc;
    logic [CW-1:0]       r_count;
    logic [1:0]          r_status;
    logic [31:0]         r_step;
    logic [63:0]         r_rd;
    logic [CW-1:0]       r_ptr;     // shift position

    // Data memory with one registered read port and one write port.
    logic [63:0]         r_mem [ame_pkg::MemDepth];
    logic [63:0]         r_mem_q;
    logic                w_we;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [63:0]         w_wdata;

    ame_pkg::t_alu_cmd   w_alu;
    logic                w_alu_done;
    logic [63:0]         w_alu_res;

    logic signed [31:0]  w_arg;
    logic                w_arg_ok;     // 0 <= arg < count
    logic                w_arg_ok_ins; // 0 <= arg <= count
    logic [4:0]          w_op;
    logic signed [31:0]  w_half;

    assign w_arg   = r_req.argument;
    assign w_op    = r_req.opcode;
    assign w_arg_ok     = !w_arg[31] && ({1'b0, w_arg} < 33'(r_count));
    assign w_arg_ok_ins = !w_arg[31] && ({1'b0, w_arg} <= 33'(r_count));
    assign w_half  = w_arg >>> 1;

    ame_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_alu),
        .o_done  (w_alu_done),
        .o_result(w_alu_res)
    );

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_mem_q <= r_mem[w_raddr];
    end

    // Read address selection; the read is registered, so the address is set in the state before the data is used.
    // A read request looks up its read index, a shift its shift position, everything else its argument.
    always_comb begin
        w_raddr = (r_req.action == ame_pkg::ACT_READ) ? r_req.read_index : w_arg[AW-1:0];
        if (r_state == S_IDLE) w_raddr = i_req.read_index;
        else if (r_state == S_SHRD) begin
            if (w_op == ame_pkg::OP_INSERT) w_raddr = AW'(r_ptr - CW'(1));
            else w_raddr = AW'(r_ptr + CW'(1));
        end
    end

    logic [63:0] w_operand;
    assign w_operand = (w_op >= ame_pkg::OP_ADDM) ? r_mem_q : {{32{w_arg[31]}}, w_arg};

    // Outcome of one instruction on a running machine: status, pointer step and
    // accumulator. Multiply and divide results arrive later from the arithmetic unit.
    logic [1:0]  n_status;
    logic [31:0] n_step;
    logic [63:0] n_acc;

    always_comb begin
        n_status = r_status;
        n_step   = 32'd1;
        n_acc    = r_acc;
        priority if (w_op >= ame_pkg::OP_ADDM && w_op <= ame_pkg::OP_DIVM && !w_arg_ok) begin
            n_status = ame_pkg::ST_ERR; n_step = '0;
        end else begin
            unique case (w_op)
                ame_pkg::OP_CLEAR: n_acc = '0;
                ame_pkg::OP_AT, ame_pkg::OP_SET, ame_pkg::OP_ERASE:
                    if (!w_arg_ok) begin
                        n_status = ame_pkg::ST_ERR; n_step = '0;
                    end else if (w_op == ame_pkg::OP_AT) n_acc = r_mem_q;
                ame_pkg::OP_INSERT:
                    if (r_count >= CW'(ame_pkg::MemDepth) || !w_arg_ok_ins) begin
                        n_status = ame_pkg::ST_ERR; n_step = '0;
                    end
                ame_pkg::OP_ADDC, ame_pkg::OP_ADDM: n_acc = r_acc + w_operand;
                ame_pkg::OP_SUBC, ame_pkg::OP_SUBM: n_acc = r_acc - w_operand;
                ame_pkg::OP_MULC, ame_pkg::OP_MULM: ;
                ame_pkg::OP_DIVC, ame_pkg::OP_DIVM:
                    if (w_operand == 64'd0) begin
                        n_status = ame_pkg::ST_ERR; n_step = '0;
                    end
                ame_pkg::OP_JREL: n_step = w_arg;
                ame_pkg::OP_JZ:  if (r_acc == 64'd0) n_step = w_arg;
                ame_pkg::OP_JNZ: if (r_acc != 64'd0) n_step = w_arg;
                ame_pkg::OP_NOOP, ame_pkg::OP_OUTPUT: ;
                ame_pkg::OP_HALT: begin
                    n_status = ame_pkg::ST_HALT; n_step = '0;
                end
                ame_pkg::OP_CHECK:
                    if (w_arg[31] || $signed({1'b0, 23'd0, r_count}) < w_half) begin
                        n_status = ame_pkg::ST_ERR; n_step = '0;
                    end
                default: begin
                    n_status = ame_pkg::ST_ERR; n_step = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = w_arg[AW-1:0];
        w_wdata = r_acc;
        w_alu   = '0;
        w_alu.a = r_acc;
        w_alu.b = w_operand;
        w_alu.is_div = (w_op == ame_pkg::OP_DIVC) || (w_op == ame_pkg::OP_DIVM);
        unique case (r_state)
            S_IDLE: if (start) n_state = S_RD;
            S_RD: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_RESP;
                if (r_req.action == ame_pkg::ACT_APPEND) begin
                    w_we    = r_count < CW'(ame_pkg::MemDepth);
                    w_waddr = r_count[AW-1:0];
                    w_wdata = r_req.data_word;
                end else if (r_req.action == ame_pkg::ACT_EXEC
                             && r_status == ame_pkg::ST_RUN) begin
                    if (w_op == ame_pkg::OP_SET && w_arg_ok) w_we = 1'b1;
                    if ((w_op == ame_pkg::OP_MULC || w_op == ame_pkg::OP_MULM ||
                         ((w_op == ame_pkg::OP_DIVC || w_op == ame_pkg::OP_DIVM) &&
                          w_operand != 64'd0)) &&
                        (w_op <= ame_pkg::OP_DIVC || w_arg_ok)) begin
                        w_alu.start = 1'b1;
                        n_state = S_ALU;
                    end
                    if (w_op == ame_pkg::OP_INSERT && r_count < CW'(ame_pkg::MemDepth)
                        && w_arg_ok_ins) n_state = S_SHRD;
                    if (w_op == ame_pkg::OP_ERASE && w_arg_ok) n_state = S_SHRD;
                end
            end
            S_ALU: if (w_alu_done) n_state = S_RESP;
            S_SHRD: begin
                // Insert moves words up from the top; erase moves them down.
                if (w_op == ame_pkg::OP_INSERT) begin
                    if (r_ptr == CW'(w_arg)) begin
                        w_we = 1'b1; w_waddr = r_ptr[AW-1:0];
                        n_state = S_RESP;
                    end else n_state = S_SHWR;
                end else begin
                    if (r_ptr + CW'(1) >= r_count) n_state = S_RESP;
                    else n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                w_we = 1'b1; w_waddr = r_ptr[AW-1:0]; w_wdata = r_mem_q;
                n_state = S_SHRD;
            end
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_count  <= '0;
            r_status <= ame_pkg::ST_RUN;
            o_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= (r_state == S_RESP);
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_req  <= i_req;
                    r_step <= '0;
                    r_rd   <= '0;
                    r_ptr  <= r_count;
                end
                S_EXEC: begin
                    if (r_req.action == ame_pkg::ACT_APPEND) begin
                        if (r_count < CW'(ame_pkg::MemDepth)) r_count <= r_count + CW'(1);
                    end else if (r_req.action == ame_pkg::ACT_READ) begin
                        if (CW'(r_req.read_index) < r_count) r_rd <= r_mem_q;
                    end else if (r_req.action == ame_pkg::ACT_EXEC
                                 && r_status == ame_pkg::ST_RUN) begin
                        if (w_op == ame_pkg::OP_ERASE) r_ptr <= CW'(w_arg);
                        r_status <= n_status;
                        r_step   <= n_step;
                        r_acc    <= n_acc;
                    end
                end
                S_ALU: if (w_alu_done) r_acc <= w_alu_res;
                S_SHRD: if (n_state == S_RESP) begin
                    if (w_op == ame_pkg::OP_INSERT) r_count <= r_count + CW'(1);
                    else r_count <= r_count - CW'(1);
                end
                S_SHWR: begin
                    if (w_op == ame_pkg::OP_INSERT) r_ptr <= r_ptr - CW'(1);
                    else r_ptr <= r_ptr + CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rsp.status    = r_status;
        o_rsp.pc_step   = r_step;
        o_rsp.acc_value = r_acc;
        o_rsp.read_word = r_rd;
        o_rsp.mem_size  = 9'(r_count);
    end

`ifndef SYNTH
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double result strobe");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ame_pkg::MemDepth)) else $error("word count overflow");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status != ame_pkg::ST_RUN |=> r_status == $past(r_status))
        else $error("stopped status changed");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("result while busy");
`endif
endmodule
